// File: src/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared constants, codes and types of the rendezvous peer table.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // Table size and derived widths
    localparam int PEER_CAPACITY = 16;
    localparam int IDX_W = (PEER_CAPACITY > 1) ? $clog2(PEER_CAPACITY) : 1;
    localparam int CNT_W = $clog2(PEER_CAPACITY + 1);

    // Request type codes (tuser of the slave side)
    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_CONNECT  = 2'd1;

    // Result kind codes (tuser of the master side)
    localparam logic [1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [1:0] KIND_PUNCH     = 2'd1;
    localparam logic [1:0] KIND_PEER      = 2'd2;

    // Request payload, id_high in the lowest bits
    typedef struct packed {
        logic [15:0] private_port;
        logic [31:0] private_ip;
        logic [15:0] src_port;
        logic [31:0] src_ip;
        logic [63:0] id_low;
        logic [63:0] id_high;
    } t_req;

    // Result payload, send_ip in the lowest bits, zero padded to bytes
    typedef struct packed {
        logic [5:0]  pad;
        logic        table_full;
        logic        peer_known;
        logic [15:0] priv_port;
        logic [31:0] priv_ip;
        logic [15:0] addr_port;
        logic [31:0] addr_ip;
        logic [15:0] send_port;
        logic [31:0] send_ip;
    } t_rsp;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [15:0] priv_port;
        logic [31:0] priv_ip;
        logic [15:0] pub_port;
        logic [31:0] pub_ip;
        logic [63:0] id_low;
        logic [63:0] id_high;
    } t_entry;

    localparam int S_TDATA_W = $bits(t_req);
    localparam int M_TDATA_W = $bits(t_rsp);
    localparam int ENTRY_W   = $bits(t_entry);

endpackage

// File: src/rpt_ram.sv
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpt_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/rpt_cmp.sv
// ----------------------------------------------------------------------------
// rpt_cmp
// Shared id compare unit: tests one stored entry against the search key.
// ----------------------------------------------------------------------------
module rpt_cmp (
    input  logic          i_vld,
    input  logic [63:0]   i_key_high,
    input  logic [63:0]   i_key_low,
    input  rpt_pkg::t_entry i_entry,
    output logic          o_hit
);

    import rpt_pkg::*;

    // 128-bit equality, gated by the entry being in use
    assign o_hit = i_vld && (i_entry.id_high == i_key_high) && (i_entry.id_low == i_key_low);

endmodule

// File: src/rendezvous_peer_table.sv
// ----------------------------------------------------------------------------
// rendezvous_peer_table
// Peer table for UDP hole punching: register and connect requests in,
// translate, punch and peer reply results out.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A request scans the table from slot
// 0 through one RAM read port and one shared 128-bit compare unit, one entry
// per cycle, stopping at the first hit; entries fill slots 0 to count-1, so
// the scan covers only slots in use. A request passes an accept state, the
// scan, a decision state, then its results, each held until the sink takes
// it. Request types other than register and connect are dropped in the
// accept cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rendezvous_peer_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Requests
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: id_high, id_low, src_ip, src_port, private_ip, private_port
    input  logic [rpt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: req_type
    input  logic [1:0]                      i_s_tuser,
    // Results
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: send_ip, send_port, addr_ip, addr_port, priv_ip, priv_port,
    //        peer_known, table_full, zero pad
    output logic [rpt_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // tuser: result_kind
    output logic [1:0]                      o_m_tuser,
    output logic                            o_m_tlast
);

    import rpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_OUT_FIRST,
        S_OUT_LAST
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [1:0]       r_type;
    logic [CNT_W-1:0] r_peer_count;
    logic [CNT_W-1:0] r_scan_cnt;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_found;
    logic [IDX_W-1:0] r_slot;
    t_entry           r_hit_entry;
    logic             r_m_tvalid;
    t_rsp             r_m_data;
    logic [1:0]       r_m_kind;
    logic             r_m_last;

    logic             s_hs;
    logic             m_hs;
    logic             issue;
    logic             hit;
    logic             room;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_entry;
    t_entry           rd_entry;
    t_req             s_req;
    t_rsp             n_m_data;

    assign s_req = i_s_tdata;
    assign s_hs  = i_s_tvalid && o_s_tready;
    assign m_hs  = r_m_tvalid && i_m_tready;

    // Scan issues a read while slots in use remain
    assign issue = (r_scan_cnt < r_peer_count);
    assign room  = (r_peer_count < CNT_W'(PEER_CAPACITY));

    // Table storage
    rpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PEER_CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_scan_cnt[IDX_W-1:0]),
        .o_rd_data (rd_entry)
    );

    // Shared id compare
    rpt_cmp u_cmp (
        .i_vld      (r_cmp_vld),
        .i_key_high (r_req.id_high),
        .i_key_low  (r_req.id_low),
        .i_entry    (rd_entry),
        .o_hit      (hit)
    );

    // Entry write on register: update the hit slot or append a new one while room remains
    always_comb begin
        wr_en              = (r_state == S_DECIDE) && (r_type == REQ_REGISTER) &&
                             (r_found || room);
        wr_addr            = r_found ? r_slot : r_peer_count[IDX_W-1:0];
        wr_entry.id_high   = r_req.id_high;
        wr_entry.id_low    = r_req.id_low;
        wr_entry.pub_ip    = r_req.src_ip;
        wr_entry.pub_port  = r_req.src_port;
        wr_entry.priv_ip   = r_req.private_ip;
        wr_entry.priv_port = r_req.private_port;
    end

    // Next result payload: translate or punch at decision, else peer reply
    always_comb begin
        n_m_data = '0;
        if (r_state == S_DECIDE) begin
            if (r_type == REQ_REGISTER) begin
                n_m_data.send_ip    = r_req.src_ip;
                n_m_data.send_port  = r_req.src_port;
                n_m_data.addr_ip    = r_req.src_ip;
                n_m_data.addr_port  = r_req.src_port;
                n_m_data.table_full = !r_found && !room;
            end else begin
                n_m_data.send_ip    = r_found ? r_hit_entry.pub_ip : '0;
                n_m_data.send_port  = r_found ? r_hit_entry.pub_port : '0;
                n_m_data.addr_ip    = r_req.src_ip;
                n_m_data.addr_port  = r_req.src_port;
                n_m_data.peer_known = r_found;
            end
        end else begin
            n_m_data.send_ip    = r_req.src_ip;
            n_m_data.send_port  = r_req.src_port;
            n_m_data.addr_ip    = r_found ? r_hit_entry.pub_ip : '0;
            n_m_data.addr_port  = r_found ? r_hit_entry.pub_port : '0;
            n_m_data.priv_ip    = r_found ? r_hit_entry.priv_ip : '0;
            n_m_data.priv_port  = r_found ? r_hit_entry.priv_port : '0;
            n_m_data.peer_known = r_found;
        end
    end

    // Sequencer, scan pipeline and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_peer_count <= '0;
            r_cmp_vld    <= 1'b0;
            r_m_tvalid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_hs) begin
                        r_req      <= s_req;
                        r_type     <= i_s_tuser;
                        r_scan_cnt <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_found    <= 1'b0;
                        if (i_s_tuser == REQ_REGISTER || i_s_tuser == REQ_CONNECT) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_found     <= 1'b1;
                        r_slot      <= r_cmp_idx;
                        r_hit_entry <= rd_entry;
                        r_cmp_vld   <= 1'b0;
                        r_state     <= S_DECIDE;
                    end else if (!issue && !r_cmp_vld) begin
                        r_state <= S_DECIDE;
                    end else begin
                        if (issue) begin
                            r_scan_cnt <= r_scan_cnt + 1'b1;
                        end
                        r_cmp_vld <= issue;
                        r_cmp_idx <= r_scan_cnt[IDX_W-1:0];
                    end
                end
                S_DECIDE: begin
                    r_m_tvalid <= 1'b1;
                    r_m_data   <= n_m_data;
                    if (r_type == REQ_REGISTER) begin
                        if (!r_found && room) begin
                            r_peer_count <= r_peer_count + 1'b1;
                        end
                        r_m_kind <= KIND_TRANSLATE;
                        r_m_last <= 1'b1;
                        r_state  <= S_OUT_LAST;
                    end else begin
                        r_m_kind <= KIND_PUNCH;
                        r_m_last <= 1'b0;
                        r_state  <= S_OUT_FIRST;
                    end
                end
                S_OUT_FIRST: begin
                    // Punch taken: follow with the peer reply
                    if (m_hs) begin
                        r_m_kind <= KIND_PEER;
                        r_m_last <= 1'b1;
                        r_m_data <= n_m_data;
                        r_state  <= S_OUT_LAST;
                    end
                end
                S_OUT_LAST: begin
                    if (m_hs) begin
                        r_m_tvalid <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_kind;
    assign o_m_tlast  = r_m_last;

`ifndef SYNTHESIS
    // No result is offered while a request is taken in or scanned
    a_no_result_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SCAN) |-> !o_m_tvalid)
        else $error("result offered outside the output states");

    // The fill count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peer_count <= CNT_W'(PEER_CAPACITY))
        else $error("peer count beyond capacity");

    // Only a punch is followed by another result of the same request
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser != KIND_PUNCH)))
        else $error("last marker does not match result kind");

    // A hit reported in the scan always concerns a slot in use
    a_hit_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && hit) |-> (CNT_W'(r_cmp_idx) < r_peer_count))
        else $error("hit on a slot not in use");
`endif

endmodule

// File: dv/rpt_checker.sv
// ----------------------------------------------------------------------------
// rpt_checker
// Watches both stream channels of the rendezvous peer table, keeps a shadow
// copy of the peer table, works out the results of every accepted request and
// compares each accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module rpt_checker
    import rpt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request channel
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // tdata: id_high, id_low, src_ip, src_port, private_ip, private_port
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    // tuser: req_type
    input  logic [1:0]             i_s_tuser,
    // Result channel
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: send_ip, send_port, addr_ip, addr_port, priv_ip, priv_port,
    //        peer_known, table_full, zero pad
    input  logic [M_TDATA_W-1:0]   i_m_tdata,
    // tuser: result_kind
    input  logic [1:0]             i_m_tuser,
    input  logic                   i_m_tlast,
    // Status toward the test top
    output int                     o_fail_count,
    output int                     o_answers_due
);

    // One outstanding result: kind, last flag and payload
    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        t_rsp       body;
    } t_answer;

    // Shadow peer table
    t_entry  peers     [PEER_CAPACITY];
    logic    peer_live [PEER_CAPACITY];
    int      peer_total = 0;

    t_answer answer_queue [$];
    int      fail_total = 0;
    int      result_no  = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_total++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      result_no, field, got, want));
        end
    endtask

    // Shadow table update and result prediction for one accepted request
    task automatic answer_request(input logic [1:0] req_kind, input t_req req);
        int      hit;
        t_answer reply;
        t_answer punch;
        hit = -1;
        for (int i = 0; i < PEER_CAPACITY; i++) begin
            if (hit < 0 && peer_live[i] && peers[i].id_high == req.id_high &&
                peers[i].id_low == req.id_low) begin
                hit = i;
            end
        end
        if (req_kind == REQ_REGISTER) begin
            reply = '0;
            reply.kind = KIND_TRANSLATE;
            reply.last = 1'b1;
            reply.body.send_ip   = req.src_ip;
            reply.body.send_port = req.src_port;
            reply.body.addr_ip   = req.src_ip;
            reply.body.addr_port = req.src_port;
            // new id goes to the next free slot, or is dropped when full
            if (hit < 0) begin
                if (peer_total < PEER_CAPACITY) begin
                    hit = peer_total;
                    peer_live[hit] = 1'b1;
                    peers[hit].id_high = req.id_high;
                    peers[hit].id_low  = req.id_low;
                    peer_total++;
                end else begin
                    reply.body.table_full = 1'b1;
                end
            end
            if (hit >= 0) begin
                peers[hit].pub_ip    = req.src_ip;
                peers[hit].pub_port  = req.src_port;
                peers[hit].priv_ip   = req.private_ip;
                peers[hit].priv_port = req.private_port;
            end
            answer_queue.push_back(reply);
        end else if (req_kind == REQ_CONNECT) begin
            punch = '0;
            reply = '0;
            punch.kind = KIND_PUNCH;
            reply.kind = KIND_PEER;
            reply.last = 1'b1;
            // unknown target leaves all target addresses at zero
            if (hit >= 0) begin
                punch.body.send_ip   = peers[hit].pub_ip;
                punch.body.send_port = peers[hit].pub_port;
                reply.body.addr_ip   = peers[hit].pub_ip;
                reply.body.addr_port = peers[hit].pub_port;
                reply.body.priv_ip   = peers[hit].priv_ip;
                reply.body.priv_port = peers[hit].priv_port;
                punch.body.peer_known = 1'b1;
                reply.body.peer_known = 1'b1;
            end
            punch.body.addr_ip   = req.src_ip;
            punch.body.addr_port = req.src_port;
            reply.body.send_ip   = req.src_ip;
            reply.body.send_port = req.src_port;
            answer_queue.push_back(punch);
            answer_queue.push_back(reply);
        end
    endtask

    // Channel monitor: results first, then the request of the same edge
    always @(posedge i_clk) begin : monitor
        t_answer want;
        t_rsp    got;
        if (!i_rst_n) begin
            for (int i = 0; i < PEER_CAPACITY; i++) begin
                peer_live[i] = 1'b0;
            end
            peer_total = 0;
            answer_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_rsp'(i_m_tdata);
                if (answer_queue.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              result_no));
                end else begin
                    want = answer_queue.pop_front();
                    check_field("result_kind", i_m_tuser, want.kind);
                    check_field("send_ip", got.send_ip, want.body.send_ip);
                    check_field("send_port", got.send_port, want.body.send_port);
                    check_field("addr_ip", got.addr_ip, want.body.addr_ip);
                    check_field("addr_port", got.addr_port, want.body.addr_port);
                    check_field("priv_ip", got.priv_ip, want.body.priv_ip);
                    check_field("priv_port", got.priv_port, want.body.priv_port);
                    check_field("peer_known", got.peer_known, want.body.peer_known);
                    check_field("table_full", got.table_full, want.body.table_full);
                    check_field("last_result", i_m_tlast, want.last);
                end
                result_no++;
            end
            if (i_s_tvalid && i_s_tready) begin
                answer_request(i_s_tuser, t_req'(i_s_tdata));
            end
        end
        o_answers_due <= answer_queue.size();
        o_fail_count  <= fail_total;
    end

endmodule

// File: dv/rendezvous_peer_table_test.sv
// ----------------------------------------------------------------------------
// rendezvous_peer_table_test
// Test top for the rendezvous peer table: directed register and connect
// requests covering the field extremes, updates, unknown targets, a full
// table and ignored types, then random traffic over a small id pool with
// bursty requests and a stalling result sink. The checker predicts and
// compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module rendezvous_peer_table_test;
    import rpt_pkg::*;

    // Request types the block drops
    localparam logic [1:0] REQ_OTHER = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int ITEM_TARGET  = 1700;
    localparam int PAUSE_EVERY  = 425;
    localparam int POOL_SIZE    = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   answers_due;

    int                   burst_left = 0;
    logic [127:0]         id_pool [POOL_SIZE];

    rendezvous_peer_table u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    rpt_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_answers_due (answers_due)
    );

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result sink: ready pattern switches among always, half, quarter and never ready modes
    initial begin : sink_stalls
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(1, 25) : $urandom_range(5, 60);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_tready <= 1'b0;
                    end
                endcase
            end
        end
    end

    function automatic t_req pack_request(input logic [63:0] hi, input logic [63:0] lo,
                                          input logic [31:0] sip, input logic [15:0] sport,
                                          input logic [31:0] pip, input logic [15:0] pport);
        t_req req;
        req.id_high      = hi;
        req.id_low       = lo;
        req.src_ip       = sip;
        req.src_port     = sport;
        req.private_ip   = pip;
        req.private_port = pport;
        return req;
    endfunction

    // One request transaction, then a random gap at the end of a burst
    task automatic send_request(input logic [1:0] req_kind, input t_req req);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= req_kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold requests back until every outstanding result has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (answers_due != 0);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int           items_sent;
        int           pick;
        logic [127:0] id;
        logic [1:0]   req_kind;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            id_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero and all-ones peers, lookups both ways
        send_request(REQ_REGISTER, pack_request('0, '0, '0, '0, '0, '0));
        send_request(REQ_REGISTER, pack_request('1, '1, '1, '1, '1, '1));
        send_request(REQ_CONNECT, pack_request('1, '1, '0, '0, '0, '0));
        send_request(REQ_CONNECT, pack_request('0, '0, '1, '1, '1, '1));
        // unknown target, one bit off a stored id
        send_request(REQ_CONNECT, pack_request('1, 64'hFFFF_FFFF_FFFF_FFFE,
                                               $urandom, 16'($urandom),
                                               $urandom, 16'($urandom)));
        // known id re-registers with new addresses
        send_request(REQ_REGISTER, pack_request('0, '0, $urandom, 16'($urandom),
                                                $urandom, 16'($urandom)));
        send_request(REQ_CONNECT, pack_request('0, '0, $urandom, 16'($urandom), '0, '0));
        // dropped request types
        send_request(REQ_OTHER, pack_request({$urandom, $urandom}, {$urandom, $urandom},
                                             $urandom, 16'($urandom),
                                             $urandom, 16'($urandom)));
        send_request(REQ_SPARE, pack_request('1, '1, '1, '1, '1, '1));
        // fill the table, then overflow it
        for (int i = 2; i < PEER_CAPACITY; i++) begin
            send_request(REQ_REGISTER, pack_request(id_pool[i][127:64], id_pool[i][63:0],
                                                    $urandom, 16'($urandom),
                                                    $urandom, 16'($urandom)));
        end
        send_request(REQ_REGISTER, pack_request(id_pool[16][127:64], id_pool[16][63:0],
                                                $urandom, 16'($urandom),
                                                $urandom, 16'($urandom)));
        send_request(REQ_CONNECT, pack_request(id_pool[16][127:64], id_pool[16][63:0],
                                               $urandom, 16'($urandom),
                                               $urandom, 16'($urandom)));
        wait_for_results();

        // Random: mostly pool ids, some near misses and fresh ids
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 85) begin
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)] ^
                     (128'd1 << $urandom_range(0, 127));
            end else begin
                id = {$urandom, $urandom, $urandom, $urandom};
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                req_kind = REQ_REGISTER;
            end else if (pick < 93) begin
                req_kind = REQ_CONNECT;
            end else begin
                req_kind = ($urandom_range(0, 1) == 1) ? REQ_SPARE : REQ_OTHER;
            end
            send_request(req_kind, pack_request(id[127:64], id[63:0],
                                                $urandom, 16'($urandom),
                                                $urandom, 16'($urandom)));
            if (req_kind == REQ_REGISTER || req_kind == REQ_CONNECT) begin
                items_sent++;
                if (items_sent % PAUSE_EVERY == 0) begin
                    wait_for_results();
                end
            end
        end

        // Drain and verdict
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && answers_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
